[design/hdbn_pkg.sv]
// ----------------------------------------------------------------------------
// HDBn encoder package
// Shared constants and types for the HDBn bipolar line encoder.
// ----------------------------------------------------------------------------
package hdbn_pkg;

	// Default upper bound and lower bound of the code order.
	localparam int MAX_ORDER_DEF = 4;
	localparam int MIN_ORDER     = 2;

	// Reset value of the code order register.
	localparam logic [2:0] ORDER_RESET = 3'd3;

	// One line symbol as held in the output queue.
	typedef struct packed {
		logic last;
		logic pos;
		logic neg;
	} hdbn_sym_t;

	// Write request from the encoder core to the symbol queue.
	typedef struct packed {
		logic append;
		logic eom;
		logic pos;
		logic neg;
		logic bal_en;
	} hdbn_wr_t;

endpackage

[design/hdbn_encode.sv]
// ----------------------------------------------------------------------------
// HDBn encoder core
// Mark and violation polarity tracking, zero run counting and the choice of
// how many held symbols are released for each bit.
// ----------------------------------------------------------------------------
module hdbn_encode #(
	parameter int MAX_ORDER = hdbn_pkg::MAX_ORDER_DEF,
	localparam int CW = $clog2(MAX_ORDER + 2)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              data_bit,
	input  logic              end_of_message,
	input  logic [2:0]        code_order,
	output hdbn_pkg::hdbn_wr_t wr,
	output logic [CW-1:0]     bal_off,
	output logic [CW-1:0]     commit_cnt
);
	import hdbn_pkg::*;

	logic          lm_q, lv_q;
	logic [CW-1:0] zr_q, fill_q;
	logic          lm_d, lv_d;
	logic [CW-1:0] zr_d, fill_d;
	logic [CW-1:0] ord, zr1, f1;
	logic          vpos, sym_pos, sym_neg, bal;

	// Saturate the configured order to the supported range.
	always_comb begin
		if (code_order < 3'(MIN_ORDER)) begin
			ord = CW'(MIN_ORDER);
		end else if (int'(code_order) > MAX_ORDER) begin
			ord = CW'(MAX_ORDER);
		end else begin
			ord = CW'(code_order);
		end
	end

	always_comb begin
		lm_d    = lm_q;
		lv_d    = lv_q;
		zr_d    = zr_q;
		sym_pos = 1'b0;
		sym_neg = 1'b0;
		bal     = 1'b0;
		zr1     = zr_q + CW'(1);
		vpos    = ~lv_q;
		f1      = fill_q + CW'(1);
		if (data_bit) begin
			zr_d    = '0;
			lm_d    = ~lm_q;
			sym_pos = ~lm_q;
			sym_neg = lm_q;
		end else if (zr1 > ord) begin
			// Run of order+1 zeros: violation, with a balancing pulse when the last
			// mark has the polarity of the previous violation and the run's first zero is held.
			sym_pos = vpos;
			sym_neg = ~vpos;
			if ((lm_q == lv_q) && (fill_q >= ord)) begin
				bal  = 1'b1;
				lm_d = vpos;
			end
			lv_d = vpos;
			zr_d = '0;
		end else begin
			zr_d = zr1;
		end

		if (end_of_message) begin
			commit_cnt = f1;
			fill_d     = '0;
			lm_d       = 1'b0;
			lv_d       = 1'b0;
			zr_d       = '0;
		end else if (f1 > ord) begin
			commit_cnt = f1 - ord;
			fill_d     = ord;
		end else begin
			commit_cnt = '0;
			fill_d     = f1;
		end
	end

	assign bal_off   = fill_q - ord;
	assign wr.append = fire;
	assign wr.eom    = end_of_message;
	assign wr.pos    = sym_pos;
	assign wr.neg    = sym_neg;
	assign wr.bal_en = bal;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lm_q   <= 1'b0;
			lv_q   <= 1'b0;
			zr_q   <= '0;
			fill_q <= '0;
		end else if (fire) begin
			lm_q   <= lm_d;
			lv_q   <= lv_d;
			zr_q   <= zr_d;
			fill_q <= fill_d;
		end
	end

endmodule

[design/hdbn_queue.sv]
// ----------------------------------------------------------------------------
// HDBn symbol queue
// Shift queue of line symbols. The head part is released for output, the
// tail part is still held so that a balancing pulse can be written back.
// ----------------------------------------------------------------------------
module hdbn_queue #(
	parameter int MAX_ORDER = hdbn_pkg::MAX_ORDER_DEF,
	localparam int CW = $clog2(MAX_ORDER + 2),
	localparam int D  = 2 * (MAX_ORDER + 1),
	localparam int NW = $clog2(D + 1),
	localparam int IW = $clog2(D)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hdbn_pkg::hdbn_wr_t wr,
	input  logic [CW-1:0]      bal_off,
	input  logic [CW-1:0]      commit_cnt,
	output logic               ready,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               positive_pulse,
	output logic               negative_pulse,
	output logic               last_symbol
);
	import hdbn_pkg::*;

	hdbn_sym_t     q_q [D];
	hdbn_sym_t     q_d [D];
	logic [NW-1:0] n_q, c_q, ns, cs, bi, n_d, c_d;
	logic          pop;

	assign out_valid      = (c_q != '0);
	assign pop            = out_valid & ~out_stall;
	assign ns             = n_q - NW'(pop);
	assign cs             = c_q - NW'(pop);
	assign ready          = (ns != NW'(D));
	assign bi             = cs + NW'(bal_off);
	assign positive_pulse = q_q[0].pos;
	assign negative_pulse = q_q[0].neg;
	assign last_symbol    = q_q[0].last;

	always_comb begin
		for (int i = 0; i < D; i++) begin
			if (!pop) begin
				q_d[i] = q_q[i];
			end else if (i == D - 1) begin
				q_d[i] = '0;
			end else begin
				q_d[i] = q_q[i + 1];
			end
		end
		n_d = ns;
		c_d = cs;
		if (wr.append) begin
			q_d[ns[IW-1:0]] = '{last: wr.eom, pos: wr.pos, neg: wr.neg};
			// The balancing pulse goes back into the still held part.
			if (wr.bal_en) begin
				q_d[bi[IW-1:0]].pos = wr.pos;
				q_d[bi[IW-1:0]].neg = wr.neg;
			end
			n_d = ns + NW'(1);
			c_d = cs + NW'(commit_cnt);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < D; i++) begin
			q_q[i] <= q_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			c_q <= '0;
		end else begin
			n_q <= n_d;
			c_q <= c_d;
		end
	end

endmodule

[design/hdbn_line_encoder_top.sv]
// ----------------------------------------------------------------------------
// HDBn line encoder
// Encodes a bit stream into HDBn bipolar pulses, order 2 to MAX_ORDER.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid/in_stall    data_bit, end_of_message
//  output   out_valid/out_stall  positive_pulse, negative_pulse, last_symbol
//  config   cfg_valid/cfg_ready  code_order
//
// One bit is taken per clock unless the input stalls. A bit waits in the
// input register before the encoder core, and its symbols leave the queue one
// per clock, so with a free output the throughput is one symbol per cycle; an
// end-of-message flush releases up to MAX_ORDER+1 symbols that drain one per cycle.
// Reset clears the polarities, the zero run and the queue counts.
// A stalled output fills the queue; the input stalls when it is full.
// ----------------------------------------------------------------------------
module hdbn_line_encoder_top #(
	parameter int MAX_ORDER = hdbn_pkg::MAX_ORDER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       data_bit,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       positive_pulse,
	output logic       negative_pulse,
	output logic       last_symbol,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] code_order
);
	import hdbn_pkg::*;

	localparam int CW = $clog2(MAX_ORDER + 2);

	logic          valid_s1, data_bit_s1, eom_s1;
	logic [2:0]    code_order_q;
	logic          q_ready, fire;
	hdbn_wr_t      wr;
	logic [CW-1:0] bal_off, commit_cnt;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 & q_ready;
	assign in_stall  = valid_s1 & ~q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_order_q <= ORDER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			code_order_q <= code_order;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			data_bit_s1 <= data_bit;
			eom_s1      <= end_of_message;
		end
	end

	hdbn_encode #(.MAX_ORDER(MAX_ORDER)) u_encode (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.data_bit      (data_bit_s1),
		.end_of_message(eom_s1),
		.code_order    (code_order_q),
		.wr            (wr),
		.bal_off       (bal_off),
		.commit_cnt    (commit_cnt)
	);

	hdbn_queue #(.MAX_ORDER(MAX_ORDER)) u_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr            (wr),
		.bal_off       (bal_off),
		.commit_cnt    (commit_cnt),
		.ready         (q_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.positive_pulse(positive_pulse),
		.negative_pulse(negative_pulse),
		.last_symbol   (last_symbol)
	);

	// A request held in the input register is not lost while the queue is full.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(data_bit_s1) && $stable(eom_s1))
		else $error("input register lost a stalled request");

	// A symbol is never both polarities.
	a_one_polarity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(positive_pulse && negative_pulse))
		else $error("symbol with both polarities");

	// Symbols are released only by a bit entering the encoder core.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fire))
		else $error("output became valid without an encoded bit");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HDBn line encoder testbench
// Drives bits and end-of-message marks into the encoder with bursty input
// and a stalling output, runs its own model of the HDBn coder on every
// accepted bit, and compares each emitted pulse with the oldest pending one.
// The code order is rewritten between phases, also in the middle of a
// message, over its whole 3-bit range.
// ----------------------------------------------------------------------------
module tb;

	import hdbn_pkg::*;

	localparam int MAX_ORDER    = MAX_ORDER_DEF;
	localparam int LINE_DEPTH   = MAX_ORDER + 1;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_LEN     = 300;
	localparam int IDLE_LIMIT   = 3000;

	typedef enum logic [1:0] {
		SYM_ZERO = 2'd0,
		SYM_POS  = 2'd1,
		SYM_NEG  = 2'd2
	} line_sym_t;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN,
		STALL_HEAVY
	} stall_t;

	logic       clk;
	logic       arst_n         = 1'b0;
	logic       in_valid       = 1'b0;
	logic       in_stall;
	logic       data_bit       = 1'b0;
	logic       end_of_message = 1'b0;
	logic       out_valid;
	logic       out_stall      = 1'b0;
	logic       positive_pulse;
	logic       negative_pulse;
	logic       last_symbol;
	logic       cfg_valid      = 1'b0;
	logic       cfg_ready;
	logic [2:0] code_order     = ORDER_RESET;

	hdbn_line_encoder_top #(
		.MAX_ORDER(MAX_ORDER)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_bit      (data_bit),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.positive_pulse(positive_pulse),
		.negative_pulse(negative_pulse),
		.last_symbol   (last_symbol),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.code_order    (code_order)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Coder model state.
	logic [2:0]  order_q   = ORDER_RESET;
	bit          mark_pos  = 1'b0;
	bit          viol_pos  = 1'b0;
	int unsigned zero_run  = 0;
	line_sym_t   held [LINE_DEPTH];
	int unsigned held_cnt  = 0;

	hdbn_sym_t pulses_due [$];

	int err_cnt      = 0;
	int bits_sent    = 0;
	int msgs_closed  = 0;
	int pulses_seen  = 0;
	int viol_cnt     = 0;
	int balance_cnt  = 0;
	bit [7:0] orders_written = '0;

	// Sender and receiver pacing.
	bit     gaps_on    = 1'b0;
	int     burst_left = 0;
	stall_t stall_mode = STALL_NONE;
	bit     hold_tog   = 1'b0;
	bit     hold_seen  = 1'b0;
	int     hold_left  = 0;
	int     pat_cnt    = 0;
	int     idle_cnt   = 0;

	function automatic int unsigned clipped_order();
		int unsigned o;
		o = order_q;
		if (o < MIN_ORDER) o = MIN_ORDER;
		if (o > MAX_ORDER) o = MAX_ORDER;
		return o;
	endfunction

	function automatic void release_oldest(bit last);
		hdbn_sym_t s;
		s.pos  = (held[0] == SYM_POS);
		s.neg  = (held[0] == SYM_NEG);
		s.last = last;
		pulses_due.push_back(s);
		for (int i = 0; i < LINE_DEPTH - 1; i++) held[i] = held[i + 1];
		held[LINE_DEPTH - 1] = SYM_ZERO;
		if (held_cnt > 0) held_cnt--;
	endfunction

	function automatic void clear_coder();
		mark_pos = 1'b0;
		viol_pos = 1'b0;
		zero_run = 0;
		held_cnt = 0;
		foreach (held[i]) held[i] = SYM_ZERO;
	endfunction

	function automatic void encode_bit(bit d, bit eom);
		int unsigned ord;
		int unsigned slot;
		line_sym_t   sym;
		bit          vpos;
		ord = clipped_order();
		while (held_cnt >= LINE_DEPTH) release_oldest(1'b0);
		slot = held_cnt;
		if (d) begin
			zero_run = 0;
			mark_pos = !mark_pos;
			sym = mark_pos ? SYM_POS : SYM_NEG;
		end else begin
			if (zero_run < 255) zero_run++;
			if (zero_run >= ord + 1) begin
				vpos = !viol_pos;
				sym = vpos ? SYM_POS : SYM_NEG;
				// The balancing pulse goes back onto the first zero of the run,
				// provided that zero is still in the delay line.
				if (mark_pos == viol_pos && slot >= ord) begin
					held[slot - ord] = sym;
					mark_pos = vpos;
					balance_cnt++;
				end
				viol_pos = vpos;
				zero_run = 0;
				viol_cnt++;
			end else begin
				sym = SYM_ZERO;
			end
		end
		held[slot] = sym;
		held_cnt = slot + 1;
		if (eom) begin
			while (held_cnt > 0) release_oldest(held_cnt == 1);
			clear_coder();
		end else begin
			while (held_cnt > ord) release_oldest(1'b0);
		end
	endfunction

	// Receiver stall pattern, with a long hold-off on request.
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen = hold_tog;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:    out_stall <= 1'b0;
				STALL_RANDOM:  out_stall <= ($urandom_range(0, 3) == 0);
				STALL_PATTERN: out_stall <= ((pat_cnt % 7) < 3);
				STALL_HEAVY:   out_stall <= ($urandom_range(0, 9) < 6);
				default:       out_stall <= 1'b0;
			endcase
		end
		pat_cnt++;
	end

	// Result checker.
	always @(posedge clk) begin : pulse_check
		hdbn_sym_t want;
		if (arst_n && out_valid && !out_stall) begin
			pulses_seen++;
			if (pulses_due.size() == 0) begin
				$error("pulse with none pending: pos %0b neg %0b last %0b",
					positive_pulse, negative_pulse, last_symbol);
				err_cnt++;
			end else begin
				want = pulses_due.pop_front();
				if (positive_pulse !== want.pos) begin
					$error("positive_pulse: expected %0b, actual %0b", want.pos, positive_pulse);
					err_cnt++;
				end
				if (negative_pulse !== want.neg) begin
					$error("negative_pulse: expected %0b, actual %0b", want.neg, negative_pulse);
					err_cnt++;
				end
				if (last_symbol !== want.last) begin
					$error("last_symbol: expected %0b, actual %0b", want.last, last_symbol);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles in which no channel moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("watchdog: %0d cycles without progress, %0d pulses pending",
					idle_cnt, pulses_due.size());
				$display("tb: errors");
				$finish;
			end
		end
	end

	task automatic send_bit(input bit d, input bit eom);
		in_valid       <= 1'b1;
		data_bit       <= d;
		end_of_message <= eom;
		do @(posedge clk); while (!(in_valid && !in_stall));
		encode_bit(d, eom);
		bits_sent++;
		if (eom) msgs_closed++;
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_pattern(input bit [31:0] bits, input int len, input bit close);
		for (int i = 0; i < len; i++) send_bit(bits[i], close && (i == len - 1));
	endtask

	task automatic send_message(input int len, input int one_pct, input bit close);
		for (int i = 0; i < len; i++)
			send_bit($urandom_range(0, 99) < one_pct, close && (i == len - 1));
	endtask

	// Lets the block run dry: nothing offered, nothing pending, pipeline empty.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pulses_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_order(input logic [2:0] v);
		wait_idle();
		cfg_valid  <= 1'b1;
		code_order <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		order_q = v;
		orders_written[v] = 1'b1;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		gaps_on = 1'b0;
		stall_mode <= STALL_NONE;
		// Violation with a balancing pulse, then one without.
		send_pattern(32'b110_0001_0000, 11, 1'b1);
		// One-bit messages and a message of zeros only.
		send_bit(1'b1, 1'b1);
		send_bit(1'b0, 1'b1);
		send_pattern(32'b0, 8, 1'b1);
	endtask

	task automatic test_order_range();
		logic [2:0] seq [8] = '{3'd0, 3'd7, 3'd2, 3'd4, 3'd1, 3'd5, 3'd6, 3'd3};
		gaps_on = 1'b1;
		stall_mode <= STALL_RANDOM;
		foreach (seq[i]) begin
			set_order(seq[i]);
			send_pattern(32'b0000_0001_1000_0010_0000_1, 21, 1'b1);
		end
	endtask

	task automatic test_order_change_open();
		gaps_on = 1'b0;
		stall_mode <= STALL_PATTERN;
		// Lower the order with a zero run partly built and the line full.
		set_order(3'd4);
		send_pattern(32'b0011, 4, 1'b0);
		set_order(3'd2);
		send_pattern(32'b1000, 4, 1'b1);
		// Raise it again in the middle of a zero run.
		send_pattern(32'b001, 3, 1'b0);
		set_order(3'd4);
		send_pattern(32'b0000_0000, 8, 1'b1);
		set_order(3'd3);
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		stall_mode <= STALL_NONE;
		wait_idle();
		hold_tog <= ~hold_tog;
		send_message(40, 30, 1'b0);
		send_message(10, 10, 1'b1);
		// The sender waits here until every pulse has come out.
		wait_idle();
		stall_mode <= STALL_HEAVY;
		send_message(30, 40, 1'b1);
	endtask

	task automatic test_random_stream();
		int one_pct [4] = '{10, 30, 50, 80};
		int goal;
		int len;
		goal = bits_sent + 210;
		while (bits_sent < goal) begin
			if ($urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 3) == 0) set_order(3'($urandom_range(0, 7)));
				else set_order(3'($urandom_range(2, 4)));
			end else if ($urandom_range(0, 3) == 0) begin
				wait_idle();
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			stall_mode <= stall_t'($urandom_range(0, 3));
			repeat ($urandom_range(1, 4)) begin
				len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 40);
				if ($urandom_range(0, 19) == 0) begin
					// Broken traffic: end marks scattered at random.
					repeat (len) send_bit($urandom_range(0, 1), $urandom_range(0, 2) == 0);
				end else begin
					send_message(len, one_pct[$urandom_range(0, 3)], $urandom_range(0, 9) != 0);
				end
			end
		end
		// Close whatever message is still open.
		send_bit($urandom_range(0, 1), 1'b1);
	endtask

	initial begin
		clear_coder();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_order_range();
		test_order_change_open();
		test_backpressure();
		test_random_stream();

		wait_idle();
		if (pulses_due.size() != 0) begin
			$error("%0d pulses never came out", pulses_due.size());
			err_cnt++;
		end
		$display("run: %0d bits, %0d closed messages, %0d pulses checked",
			bits_sent, msgs_closed, pulses_seen);
		$display("run: %0d violations, %0d balancing pulses, order values written %b",
			viol_cnt, balance_cnt, orders_written);
		if (err_cnt == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

[hdbn_line_encoder_top.f]
design/hdbn_pkg.sv
design/hdbn_encode.sv
design/hdbn_queue.sv
design/hdbn_line_encoder_top.sv
verif/tb.sv
